// ===== sv/cta_pkg.sv =====
// Shared types and constants for the CRTC timing adjustment block.
package cta_pkg;

   localparam int NSTAGE     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;
   localparam int REQ_W      = 72;
   localparam int RSP_W      = 96;

   typedef logic signed [11:0] vval_type;
   typedef logic signed [9:0]  hval_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCANLINE = 2'd0,
      CSR_OFFSET_X = 2'd1,
      CSR_OFFSET_Y = 2'd2
   } csr_index_type;

   localparam logic [7:0] MISC_WIDE_SYNC = 8'hE7;
   localparam logic [7:0] HTOT_WIDE      = 8'h96;
   localparam logic [4:0] HW_NARROW      = 5'd10;
   localparam logic [4:0] HW_MISC        = 5'd11;
   localparam hval_type   HB_CUSHION     = 10'sd2;
   localparam vval_type   VGAP_MIN       = 12'sd40;
   localparam vval_type   VTOT_CUSHION   = 12'sd9;
   localparam vval_type   VRE_WIDTH      = 12'sd2;
   localparam logic [7:0] MSL_DOUBLE     = 8'h40;
   localparam logic [7:0] VRE_FIXED      = 8'hA0;
   localparam logic [7:0] HBE_FIXED      = 8'h80;
   // Overflow bits that survive centring: retrace start and blanking start bits are rebuilt.
   localparam logic [7:0] OVF_KEEP       = 8'h73;

   typedef struct packed {
      logic              scanline;
      logic signed [5:0] offset_x;
      logic signed [5:0] offset_y;
   } cfg_type;

   typedef struct packed {
      logic [NSTAGE-1:0] load;
   } ctl_type;

   typedef struct packed {
      logic [7:0] v_display_end_low;
      logic [7:0] v_retrace_begin_low;
      logic [7:0] max_scanline_in;
      logic [7:0] overflow_in;
      logic [7:0] v_total_low;
      logic [7:0] h_retrace_begin;
      logic [7:0] h_display_end;
      logic [7:0] h_total;
      logic [7:0] misc_output;
   } req_type;

   typedef struct packed {
      logic [7:0] v_blank_end_out;
      logic [7:0] v_blank_start_out;
      logic [7:0] v_retrace_end_out;
      logic [7:0] v_retrace_start_out;
      logic [7:0] v_display_end_out;
      logic [7:0] max_scanline_out;
      logic [7:0] overflow_out;
      logic [7:0] v_total_out;
      logic [7:0] h_blank_end_out;
      logic [7:0] h_blank_start_out;
      logic [7:0] h_retrace_end_out;
      logic [7:0] h_retrace_start_out;
   } rsp_type;

endpackage

// ===== sv/cta_datapath.sv =====
// Four-stage datapath: scanline halving, horizontal centring and vertical centring.
module cta_datapath (
   input  logic                     clock,
   input  cta_pkg::cfg_type         cfg,
   input  cta_pkg::ctl_type         ctl,
   input  logic [cta_pkg::REQ_W-1:0] req_data,
   output logic [cta_pkg::RSP_W-1:0] rsp_data
);

   typedef struct packed {
      logic              halve;
      cta_pkg::vval_type yt_out;
      cta_pkg::vval_type yd_out;
      cta_pkg::vval_type vro;
      logic [7:0]        vtot;
      logic [7:0]        ovf;
      logic [7:0]        msl;
      logic [7:0]        vrs;
      logic [7:0]        vend;
      logic [7:0]        htot;
      logic [7:0]        hdisp;
      cta_pkg::hval_type hr_start;
      logic [4:0]        hw;
   } s1_type;

   typedef struct packed {
      logic [7:0] vtot;
      logic [7:0] ovf;
      logic [7:0] msl;
      logic [7:0] vrs;
      logic [7:0] vend;
      logic [7:0] hrs_out;
      logic [7:0] hre_out;
      logic [7:0] hbs_out;
      logic [7:0] hbe_out;
   } s2_type;

   typedef struct packed {
      logic [7:0]        hrs_out;
      logic [7:0]        hre_out;
      logic [7:0]        hbs_out;
      logic [7:0]        hbe_out;
      logic [7:0]        vtot;
      logic [7:0]        ovf;
      logic [7:0]        msl;
      logic [7:0]        vend;
      cta_pkg::vval_type vr_start;
      cta_pkg::vval_type vdisp;
      cta_pkg::vval_type vtotal;
   } s3_type;

   cta_pkg::req_type req;
   s1_type           s1_ff, s1_in;
   s2_type           s2_ff, s2_in;
   s3_type           s3_ff, s3_in;
   cta_pkg::rsp_type rsp_ff, rsp_in;

   assign req = req_data;

   always_comb begin
      cta_pkg::vval_type yt_in;
      cta_pkg::vval_type yd_in;
      cta_pkg::vval_type yd_out;
      cta_pkg::vval_type yt_half;
      cta_pkg::vval_type vrs_half;
      cta_pkg::vval_type vro_pick;
      cta_pkg::hval_type shift;
      cta_pkg::hval_type hr_raw;
      cta_pkg::hval_type hdisp10;
      logic              short_gap;
      logic              wide;
      logic [4:0]        hw;
      yt_in    = cta_pkg::vval_type'({2'b00, req.overflow_in[5], req.overflow_in[0],
                                      req.v_total_low});
      yd_in    = cta_pkg::vval_type'({2'b00, req.overflow_in[6], req.overflow_in[1],
                                      req.v_display_end_low}) + 12'sd1;
      yd_out   = (yd_in >>> 1) - 12'sd1;
      yt_half  = yt_in >>> 1;
      vrs_half = cta_pkg::vval_type'({2'b00, req.overflow_in[7], req.overflow_in[2],
                                      req.v_retrace_begin_low}) >>> 1;
      short_gap = ((yt_in - yd_in) < cta_pkg::VGAP_MIN) && (cfg.offset_y == 6'sd0);
      vro_pick  = short_gap ? yd_out : vrs_half;

      s1_in.halve  = cfg.scanline & req.max_scanline_in[0];
      s1_in.yt_out = short_gap ? yt_half + cta_pkg::VRE_WIDTH : yt_half;
      s1_in.yd_out = yd_out;
      s1_in.vro    = (vro_pick < yd_out) ? yd_out : vro_pick;
      s1_in.vtot   = req.v_total_low;
      s1_in.ovf    = req.overflow_in;
      s1_in.msl    = req.max_scanline_in;
      s1_in.vrs    = req.v_retrace_begin_low;
      s1_in.vend   = req.v_display_end_low;
      s1_in.htot   = req.h_total;
      s1_in.hdisp  = req.h_display_end;

      wide    = req.h_total > cta_pkg::HTOT_WIDE;
      hw      = (req.misc_output == cta_pkg::MISC_WIDE_SYNC) ? cta_pkg::HW_MISC
                                                            : cta_pkg::HW_NARROW;
      shift   = {{4{cfg.offset_x[5]}}, cfg.offset_x};
      if (wide) begin
         shift = shift <<< 1;
         hw    = hw << 1;
      end
      hr_raw  = cta_pkg::hval_type'({2'b00, req.h_retrace_begin}) + shift;
      hdisp10 = cta_pkg::hval_type'({2'b00, req.h_display_end});
      s1_in.hr_start = (hr_raw <= hdisp10) ? hdisp10 + 10'sd1 : hr_raw;
      s1_in.hw       = hw;
   end

   always_comb begin
      cta_pkg::vval_type vre;
      cta_pkg::vval_type vbe;
      cta_pkg::vval_type vbs;
      cta_pkg::vval_type yt_a;
      cta_pkg::vval_type yt_b;
      cta_pkg::hval_type htot10;
      cta_pkg::hval_type hdisp_next;
      cta_pkg::hval_type hr_end;
      cta_pkg::hval_type hb_end;
      cta_pkg::hval_type hb_start;
      logic [7:0]        nov;
      logic [7:0]        nms;
      vre  = s1_ff.vro + cta_pkg::VRE_WIDTH;
      yt_a = (vre > s1_ff.yt_out - cta_pkg::VTOT_CUSHION) ? vre + cta_pkg::VTOT_CUSHION
                                                          : s1_ff.yt_out;
      vbs  = s1_ff.yd_out + 12'sd1;
      if (vbs > vre) begin
         vbs = vre;
      end
      vbe  = vre + 12'sd1;
      yt_b = (vbe > yt_a - cta_pkg::VTOT_CUSHION) ? vbe + cta_pkg::VTOT_CUSHION : yt_a;
      nov  = {s1_ff.vro[9], s1_ff.yd_out[9], yt_b[9], 1'b0,
              vbs[8], s1_ff.vro[8], s1_ff.yd_out[8], yt_b[8]};
      nms  = cta_pkg::MSL_DOUBLE | {2'b00, vbs[9], 5'b00000};

      if (s1_ff.halve) begin
         s2_in.vtot = yt_b[7:0];
         s2_in.ovf  = nov;
         s2_in.msl  = nms;
         s2_in.vrs  = s1_ff.vro[7:0];
         s2_in.vend = s1_ff.yd_out[7:0];
      end else begin
         s2_in.vtot = s1_ff.vtot;
         s2_in.ovf  = s1_ff.ovf;
         s2_in.msl  = s1_ff.msl;
         s2_in.vrs  = s1_ff.vrs;
         s2_in.vend = s1_ff.vend;
      end

      htot10     = cta_pkg::hval_type'({2'b00, s1_ff.htot});
      hdisp_next = cta_pkg::hval_type'({2'b00, s1_ff.hdisp}) + 10'sd1;
      hr_end     = s1_ff.hr_start + cta_pkg::hval_type'({5'b00000, s1_ff.hw});
      if (hr_end > htot10) begin
         hr_end = htot10;
      end
      hb_start   = (hdisp_next > s1_ff.hr_start) ? s1_ff.hr_start : hdisp_next;
      hb_end     = hr_end + cta_pkg::HB_CUSHION;
      if (hb_end > htot10) begin
         hb_end = htot10;
      end
      s2_in.hrs_out = s1_ff.hr_start[7:0];
      s2_in.hre_out = {hb_end[5], 2'b00, hr_end[4:0]};
      s2_in.hbs_out = hb_start[7:0];
      s2_in.hbe_out = cta_pkg::HBE_FIXED | {3'b000, hb_end[4:0]};
   end

   always_comb begin
      cta_pkg::vval_type vr_raw;
      cta_pkg::vval_type vdisp;
      vr_raw = cta_pkg::vval_type'({2'b00, s2_ff.ovf[7], s2_ff.ovf[2], s2_ff.vrs})
             + cta_pkg::vval_type'({{6{cfg.offset_y[5]}}, cfg.offset_y});
      vdisp  = cta_pkg::vval_type'({2'b00, s2_ff.ovf[6], s2_ff.ovf[1], s2_ff.vend}) + 12'sd1;
      s3_in.hrs_out  = s2_ff.hrs_out;
      s3_in.hre_out  = s2_ff.hre_out;
      s3_in.hbs_out  = s2_ff.hbs_out;
      s3_in.hbe_out  = s2_ff.hbe_out;
      s3_in.vtot     = s2_ff.vtot;
      s3_in.ovf      = s2_ff.ovf;
      s3_in.msl      = s2_ff.msl;
      s3_in.vend     = s2_ff.vend;
      s3_in.vr_start = (vr_raw < vdisp) ? vdisp : vr_raw;
      s3_in.vdisp    = vdisp;
      s3_in.vtotal   = cta_pkg::vval_type'({2'b00, s2_ff.ovf[5], s2_ff.ovf[0], s2_ff.vtot});
   end

   always_comb begin
      cta_pkg::vval_type vr_end;
      cta_pkg::vval_type vb_start;
      cta_pkg::vval_type vb_end;
      vr_end = s3_ff.vr_start + cta_pkg::VRE_WIDTH;
      if (vr_end > s3_ff.vtotal) begin
         vr_end = s3_ff.vtotal;
      end
      vb_start = s3_ff.vdisp + 12'sd1;
      if (vb_start > s3_ff.vr_start) begin
         vb_start = s3_ff.vr_start;
      end
      vb_end = vr_end + cta_pkg::VRE_WIDTH;
      if (vb_end > s3_ff.vtotal) begin
         vb_end = s3_ff.vtotal;
      end
      rsp_in.h_retrace_start_out = s3_ff.hrs_out;
      rsp_in.h_retrace_end_out   = s3_ff.hre_out;
      rsp_in.h_blank_start_out   = s3_ff.hbs_out;
      rsp_in.h_blank_end_out     = s3_ff.hbe_out;
      rsp_in.v_total_out         = s3_ff.vtot;
      rsp_in.overflow_out        = (s3_ff.ovf & cta_pkg::OVF_KEEP)
                                 | {s3_ff.vr_start[9], 3'b000, vb_start[8],
                                    s3_ff.vr_start[8], 2'b00};
      rsp_in.max_scanline_out    = {s3_ff.msl[7:6], vb_start[9], s3_ff.msl[4:0]};
      rsp_in.v_display_end_out   = s3_ff.vend;
      rsp_in.v_retrace_start_out = s3_ff.vr_start[7:0];
      rsp_in.v_retrace_end_out   = cta_pkg::VRE_FIXED | {4'h0, vr_end[3:0]};
      rsp_in.v_blank_start_out   = vb_start[7:0];
      rsp_in.v_blank_end_out     = vb_end[7:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         s1_ff <= s1_in;
      end
      if (ctl.load[1]) begin
         s2_ff <= s2_in;
      end
      if (ctl.load[2]) begin
         s3_ff <= s3_in;
      end
      if (ctl.load[3]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== sv/crtc_timing_adjust.sv =====
// Top level of the CRTC timing adjustment block: handshakes, pipeline control and registers.
//
// One mode's timing bytes enter per beat and one adjusted set of timing bytes leaves per beat.
// The block takes a new beat in every cycle unless back-pressure holds it; each request beat
// passes through the registers of the four-stage pipeline (halving, horizontal clamps, vertical
// centring, output register) before its result beat is offered. Back-pressure on the result
// side stalls only the full stages between the output register and the first empty stage and
// leaves the other stages free to move. The three registers (scanline halving, horizontal and
// vertical offset) are written through the csr channel, which is always ready, and are to be
// changed only while no beat is in flight; a write to an unused index is ignored.
module crtc_timing_adjust (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // misc_output, h_total, h_display_end, h_retrace_begin, v_total_low, overflow_in,
   // max_scanline_in, v_retrace_begin_low, v_display_end_low (8 bits each)
   input  logic [cta_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // h_retrace_start_out, h_retrace_end_out, h_blank_start_out, h_blank_end_out,
   // v_total_out, overflow_out, max_scanline_out, v_display_end_out,
   // v_retrace_start_out, v_retrace_end_out, v_blank_start_out, v_blank_end_out (8 bits each)
   output logic [cta_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cta_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cta_pkg::CSR_DATA_W-1:0] csr_data
);

   logic [cta_pkg::NSTAGE-1:0] valid_ff, valid_in;
   logic [cta_pkg::NSTAGE-1:0] adv;
   cta_pkg::cfg_type           cfg_ff, cfg_in;
   cta_pkg::ctl_type           ctl;

   always_comb begin
      adv[cta_pkg::NSTAGE-1] = !valid_ff[cta_pkg::NSTAGE-1] || rsp_tready;
      for (int k = cta_pkg::NSTAGE - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      valid_in[0] = adv[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < cta_pkg::NSTAGE; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign ctl.load   = adv;
   assign req_tready = adv[0];
   assign rsp_tvalid = valid_ff[cta_pkg::NSTAGE-1];
   assign csr_ready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cta_pkg::CSR_SCANLINE: cfg_in.scanline = csr_data[0];
            cta_pkg::CSR_OFFSET_X: cfg_in.offset_x = csr_data;
            cta_pkg::CSR_OFFSET_Y: cfg_in.offset_y = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cfg_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cfg_ff   <= cfg_in;
      end
   end

   cta_datapath u_datapath (
      .clock    (clock),
      .cfg      (cfg_ff),
      .ctl      (ctl),
      .req_data (req_tdata),
      .rsp_data (rsp_tdata)
   );

endmodule

// ===== sv/cta_checker.sv =====
// Port-level checks on the CRTC timing adjustment block, bound to its top level.
module cta_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [cta_pkg::RSP_W-1:0] rsp_tdata
);

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result beat shown straight after reset.");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result beat changed or vanished.");

   a_ready_when_drained : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("Request side stalled while the output register is empty.");

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("Result beat missing four cycles after an unstalled request beat.");

   a_fixed_bits : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31] && rsp_tdata[79] && rsp_tdata[77]
                     && !rsp_tdata[14] && !rsp_tdata[13])
      else $error("Constant bits of the retrace or blanking end bytes are wrong.");

endmodule

bind crtc_timing_adjust cta_checker u_checker (.*);

// ===== tb/crtc_timing_adjust_test.sv =====
// Self-checking testbench for crtc_timing_adjust with a built-in predictor of the timing rules.
module crtc_timing_adjust_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [cta_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int NPHASE = 9;
   localparam int MODES_PER_PHASE = 222;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [cta_pkg::REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [cta_pkg::RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [cta_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [cta_pkg::CSR_DATA_W-1:0] csr_data = '0;

   cta_pkg::req_type mode_queue[$];
   cta_pkg::rsp_type timing_expected[$];
   logic [cta_pkg::RSP_W-1:0] timing_want;
   bit req_fired = 1'b0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fail_count = 0;

   bit cfg_halving = 1'b0;
   int cfg_offset_x = 0;
   int cfg_offset_y = 0;

   string timing_field_name[12] = '{
      "h_retrace_start_out", "h_retrace_end_out", "h_blank_start_out", "h_blank_end_out",
      "v_total_out", "overflow_out", "max_scanline_out", "v_display_end_out",
      "v_retrace_start_out", "v_retrace_end_out", "v_blank_start_out", "v_blank_end_out"
   };

   int phase_halving[NPHASE] = '{1, 0, 1, 1, 0, 1, 0, 1, 0};
   int phase_offset_x[NPHASE] = '{0, 31, -32, 5, -1, -7, -32, 31, 0};
   int phase_offset_y[NPHASE] = '{0, -32, 31, 0, 1, -3, 31, -32, 0};

   crtc_timing_adjust u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic cta_pkg::rsp_type adjust_timing(input cta_pkg::req_type m);
      int htot, hdisp, hrs, vtot, ovf, msl, vrs, vend;
      int hw, shift, hr_start, hr_end, hb_start, hb_end;
      int vr_start, vr_end, vdisp, vtotal, vb_start, vb_end;
      int yt_in, yt_out, yd_in, yd_out, vro, vre, vbs, vbe, nov, nms;
      cta_pkg::rsp_type r;
      htot = int'(m.h_total);
      hdisp = int'(m.h_display_end);
      hrs = int'(m.h_retrace_begin);
      vtot = int'(m.v_total_low);
      ovf = int'(m.overflow_in);
      msl = int'(m.max_scanline_in);
      vrs = int'(m.v_retrace_begin_low);
      vend = int'(m.v_display_end_low);

      // Line-doubled modes are rebuilt at half height before centring.
      if (cfg_halving && msl[0]) begin
         yt_in = vtot | ((ovf & 'h01) << 8) | ((ovf & 'h20) << 4);
         yt_out = yt_in >>> 1;
         yd_in = vend | ((ovf & 'h02) << 7) | ((ovf & 'h40) << 3);
         yd_in = yd_in + 1;
         yd_out = (yd_in >>> 1) - 1;
         nov = ((yd_out & 'h100) >> 7) | ((yd_out & 'h200) >> 3);
         vend = yd_out & 'hff;
         if ((yt_in - yd_in) < int'(cta_pkg::VGAP_MIN) && cfg_offset_y == 0) begin
            vro = yd_out;
            yt_out = yt_out + 2;
         end else begin
            vro = vrs | ((ovf & 'h04) << 6) | ((ovf & 'h80) << 2);
            vro = vro >>> 1;
         end
         if (vro < yd_out) vro = yd_out;
         nov = nov | ((vro & 'h100) >> 6) | ((vro & 'h200) >> 2);
         vrs = vro & 'hff;
         vre = vro + 2;
         if (vre > yt_out - 9) yt_out = vre + 9;
         vbs = yd_out + 1;
         if (vbs > vre) vbs = vre;
         nov = nov | ((vbs & 'h100) >> 5);
         nms = int'(cta_pkg::MSL_DOUBLE) | ((vbs & 'h200) >> 4);
         vbe = vre + 1;
         if (vbe > yt_out - 9) yt_out = vbe + 9;
         nov = nov | ((yt_out & 'h100) >> 8) | ((yt_out & 'h200) >> 4);
         vtot = yt_out & 'hff;
         ovf = nov & 'hff;
         msl = nms;
      end

      hw = (m.misc_output == cta_pkg::MISC_WIDE_SYNC) ? int'(cta_pkg::HW_MISC)
                                                      : int'(cta_pkg::HW_NARROW);
      shift = cfg_offset_x;
      if (htot > int'(cta_pkg::HTOT_WIDE)) begin
         shift = shift * 2;
         hw = hw * 2;
      end
      hr_start = hrs + shift;
      if (hr_start <= hdisp) hr_start = hdisp + 1;
      hr_end = hr_start + hw;
      if (hr_end > htot) hr_end = htot;
      hb_start = hdisp + 1;
      if (hb_start > hr_start) hb_start = hr_start & 'hff;
      hb_end = hr_end + 2;
      if (hb_end > htot) hb_end = htot;

      vr_start = vrs | ((ovf & 'h04) << 6) | ((ovf & 'h80) << 2);
      vr_start = vr_start + cfg_offset_y;
      vdisp = vend | ((ovf & 'h02) << 7) | ((ovf & 'h40) << 3);
      vdisp = vdisp + 1;
      if (vr_start < vdisp) vr_start = vdisp;
      vtotal = vtot | ((ovf & 'h01) << 8) | ((ovf & 'h20) << 4);
      ovf = ovf & 'h7b;
      ovf = ovf | ((vr_start & 'h100) >> 6) | ((vr_start & 'h200) >> 2);
      vr_end = vr_start + 2;
      if (vr_end > vtotal) vr_end = vtotal;
      vb_start = vdisp + 1;
      if (vb_start > vr_start) vb_start = vr_start;
      vb_end = vr_end + 2;
      if (vb_end > vtotal) vb_end = vtotal;
      ovf = (ovf & 'hf7) | ((vb_start & 'h100) >> 5);
      msl = (msl & 'hdf) | ((vb_start & 'h200) >> 4);

      r.h_retrace_start_out = hr_start[7:0];
      r.h_retrace_end_out = {hb_end[5], 2'b00, hr_end[4:0]};
      r.h_blank_start_out = hb_start[7:0];
      r.h_blank_end_out = cta_pkg::HBE_FIXED | {3'b000, hb_end[4:0]};
      r.v_total_out = vtot[7:0];
      r.overflow_out = ovf[7:0];
      r.max_scanline_out = msl[7:0];
      r.v_display_end_out = vend[7:0];
      r.v_retrace_start_out = vr_start[7:0];
      r.v_retrace_end_out = cta_pkg::VRE_FIXED | {4'b0000, vr_end[3:0]};
      r.v_blank_start_out = vb_start[7:0];
      r.v_blank_end_out = vb_end[7:0];
      return r;
   endfunction

   function automatic cta_pkg::req_type mode_bytes(input logic [7:0] misc, ht, hd, hr, vt, ov,
                                                   ms, vr, vd);
      cta_pkg::req_type m;
      m.misc_output = misc;
      m.h_total = ht;
      m.h_display_end = hd;
      m.h_retrace_begin = hr;
      m.v_total_low = vt;
      m.overflow_in = ov;
      m.max_scanline_in = ms;
      m.v_retrace_begin_low = vr;
      m.v_display_end_low = vd;
      return m;
   endfunction

   // Most modes are plausible ones around the clamp boundaries; the rest are raw bytes.
   function automatic cta_pkg::req_type random_mode();
      cta_pkg::req_type m;
      int yt, yd, yr;
      if ($urandom_range(9) < 3) begin
         m = mode_bytes(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
      end else begin
         m.misc_output = ($urandom_range(3) == 0) ? cta_pkg::MISC_WIDE_SYNC
                                                  : 8'($urandom_range(255));
         m.h_total = 8'($urandom_range(8'h40, 8'hc0));
         m.h_display_end = m.h_total - 8'($urandom_range(4, 32));
         m.h_retrace_begin = m.h_display_end + 8'($urandom_range(8)) - 8'd2;
         yt = int'($urandom_range(200, 1023));
         yd = yt - int'($urandom_range(80));
         yr = yd + int'($urandom_range(20)) - 3;
         if (yr < 0) yr = 0;
         if (yr > 1023) yr = 1023;
         m.v_total_low = yt[7:0];
         m.v_display_end_low = yd[7:0];
         m.v_retrace_begin_low = yr[7:0];
         m.overflow_in = {yr[9], yd[9], yt[9], 2'($urandom_range(3)), yr[8], yd[8], yt[8]};
         m.max_scanline_in = 8'($urandom_range(255));
      end
      return m;
   endfunction

   task automatic write_csr(input logic [cta_pkg::CSR_IDX_W-1:0] idx,
                            input logic [cta_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         cta_pkg::CSR_SCANLINE: cfg_halving = val[0];
         cta_pkg::CSR_OFFSET_X: cfg_offset_x = $signed(val);
         cta_pkg::CSR_OFFSET_Y: cfg_offset_y = $signed(val);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      req_fired = !reset && req_tvalid && req_tready;
      if (req_fired) begin
         timing_expected.push_back(adjust_timing(cta_pkg::req_type'(req_tdata)));
         void'(mode_queue.pop_front());
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (mode_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= mode_queue[0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (timing_expected.size() == 0) begin
            $error("result beat arrived with no expectation waiting");
            fail_count++;
         end else begin
            timing_want = timing_expected.pop_front();
            for (int i = 0; i < 12; i++) begin
               if (rsp_tdata[8*i +: 8] !== timing_want[8*i +: 8]) begin
                  $error("%s: expected %02h, got %02h", timing_field_name[i],
                         timing_want[8*i +: 8], rsp_tdata[8*i +: 8]);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NPHASE; p++) begin
         case (p / 3)
            0: begin
               send_idle_pct = 23;
               recv_idle_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_idle_pct = 23;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_csr(cta_pkg::CSR_SCANLINE, cta_pkg::CSR_DATA_W'(phase_halving[p]));
         write_csr(cta_pkg::CSR_OFFSET_X, cta_pkg::CSR_DATA_W'(phase_offset_x[p]));
         write_csr(cta_pkg::CSR_OFFSET_Y, cta_pkg::CSR_DATA_W'(phase_offset_y[p]));
         write_csr(CSR_SPARE, cta_pkg::CSR_DATA_W'($urandom_range(63)));

         if (p == 0) begin
            mode_queue.push_back(mode_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                            8'h00, 8'h00));
            mode_queue.push_back(mode_bytes(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                                            8'hff, 8'hff));
            mode_queue.push_back(mode_bytes(8'he3, 8'h5f, 8'h4f, 8'h54, 8'h0b, 8'h3e, 8'h40,
                                            8'hea, 8'hdf));
            mode_queue.push_back(mode_bytes(8'he7, 8'h5f, 8'h4f, 8'h54, 8'h0b, 8'h3e, 8'h41,
                                            8'hea, 8'hdf));
            mode_queue.push_back(mode_bytes(8'h63, 8'h5f, 8'h4f, 8'h54, 8'hbf, 8'h1f, 8'h41,
                                            8'h9c, 8'h8f));
            // A short gap between total and display end pulls retrace to display end.
            mode_queue.push_back(mode_bytes(8'he3, 8'h5f, 8'h4f, 8'h54, 8'hf0, 8'h1f, 8'h01,
                                            8'he0, 8'hdf));
            // Halving a display end of zero leaves minus one.
            mode_queue.push_back(mode_bytes(8'he3, 8'h5f, 8'h4f, 8'h54, 8'h20, 8'h00, 8'h01,
                                            8'h10, 8'h00));
            mode_queue.push_back(mode_bytes(8'he3, 8'h5f, 8'h4f, 8'h54, 8'hff, 8'h61, 8'h01,
                                            8'hff, 8'h80));
            mode_queue.push_back(mode_bytes(8'he3, 8'h5f, 8'h4f, 8'h54, 8'h90, 8'h11, 8'h03,
                                            8'h60, 8'h40));
            mode_queue.push_back(mode_bytes(8'he7, 8'h96, 8'h80, 8'h85, 8'h0b, 8'h3e, 8'h40,
                                            8'hea, 8'hdf));
            mode_queue.push_back(mode_bytes(8'he7, 8'h97, 8'h80, 8'h85, 8'h0b, 8'h3e, 8'h40,
                                            8'hea, 8'hdf));
            mode_queue.push_back(mode_bytes(8'he6, 8'h97, 8'h80, 8'h85, 8'h0b, 8'h3e, 8'h40,
                                            8'hea, 8'hdf));
            mode_queue.push_back(mode_bytes(8'he8, 8'h5f, 8'h4f, 8'h54, 8'h0b, 8'h3e, 8'h40,
                                            8'hea, 8'hdf));
            // Horizontal retrace start beyond eight bits.
            mode_queue.push_back(mode_bytes(8'he3, 8'hff, 8'hff, 8'hff, 8'h0b, 8'h3e, 8'h40,
                                            8'hea, 8'hdf));
            mode_queue.push_back(mode_bytes(8'he3, 8'h60, 8'h50, 8'h20, 8'h0b, 8'h3e, 8'h40,
                                            8'hea, 8'hdf));
            mode_queue.push_back(mode_bytes(8'he3, 8'h00, 8'h10, 8'h12, 8'h0b, 8'h3e, 8'h40,
                                            8'hea, 8'hdf));
            // Vertical retrace start beyond ten bits.
            mode_queue.push_back(mode_bytes(8'he3, 8'h5f, 8'h4f, 8'h54, 8'hff, 8'he7, 8'h00,
                                            8'hff, 8'hff));
            mode_queue.push_back(mode_bytes(8'he3, 8'h5f, 8'h4f, 8'h54, 8'h10, 8'h00, 8'h00,
                                            8'hf0, 8'he0));
         end
         for (int k = 0; k < MODES_PER_PHASE; k++) mode_queue.push_back(random_mode());

         while (mode_queue.size() != 0 || timing_expected.size() != 0) @(posedge clock);
         repeat (cta_pkg::NSTAGE + 4) @(posedge clock);
      end

      repeat (4 * cta_pkg::NSTAGE) @(posedge clock);
      if (fail_count == 0 && timing_expected.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
